// File: rtl/core/gtg_pkg.sv
`default_nettype none
package gtg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int MAX_STEPS    = 24;
  localparam int NSTEPS       = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  // Rotation datapath width: 17-bit offset, 8 guard bits, growth below 2x.
  localparam int RW = 28;
  // Angle width, Q.28 radians with headroom for the pi fold.
  localparam int ZW = 32;
  // Vectoring datapath width: lin values up to 27 bits, 8 guard bits, growth.
  localparam int VW = 48;

  localparam logic signed [ZW-1:0] PI_Q28      = 32'sd843314856;
  localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic [23:0]          GAIN_K_Q24  = 24'd10188014;

  localparam logic [1:0] ST_NO_POSE = 2'd0;
  localparam logic [1:0] ST_REACHED = 2'd1;
  localparam logic [1:0] ST_DRIVE   = 2'd2;

  localparam logic [1:0] REG_TOL  = 2'd0;
  localparam logic [1:0] REG_LIN  = 2'd1;
  localparam logic [1:0] REG_ANG  = 2'd2;

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_heading;
    logic               pose_valid;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] forward_speed;
    logic signed [15:0] turn_rate;
  } out_word_t;

  typedef struct packed {
    logic [14:0] goal_tolerance;
    logic [11:0] linear_gain;
    logic [11:0] angular_gain;
  } cfg_t;

  function automatic logic signed [ZW-1:0] atan_q28(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 32'sd210828714;
      1: r = 32'sd124459457;
      2: r = 32'sd65760959;
      3: r = 32'sd33381289;
      4: r = 32'sd16755422;
      5: r = 32'sd8385879;
      6: r = 32'sd4193961;
      7: r = 32'sd2097109;
      8: r = 32'sd1048571;
      9: r = 32'sd524287;
      default: r = 32'sd1 <<< (28 - i);
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) r = 16'sh7fff;
    else if (v < -48'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/go_to_goal_steering_core.sv
`default_nettype none
// Start passes through the rotation front end, the scaling stages and the vectoring CORDIC, all registered, to done.
// Throughput: one word per cycle; busy is always low, both CORDICs are fully unrolled.
// The result is shown for one cycle with done high; the receiver cannot stall.
// Synchronous active-high reset clears all valid bits and loads the register defaults.
module go_to_goal_steering_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire gtg_pkg::in_word_t  in_word,
  output logic                    done,
  output gtg_pkg::out_word_t      out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import gtg_pkg::*;

  cfg_t cfg;
  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.goal_tolerance <= 15'd10;
      cfg.linear_gain    <= 12'd512;
      cfg.angular_gain   <= 12'd512;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOL: cfg.goal_tolerance <= cfg_data[14:0];
        REG_LIN: cfg.linear_gain    <= cfg_data[11:0];
        REG_ANG: cfg.angular_gain   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic r_v, r_d;
  logic [1:0] r_s;
  logic signed [RW-1:0] r_x, r_y;
  logic l_v, l_d;
  logic [1:0] l_s;
  logic signed [47:0] l_x, l_y;

  gtg_rotate u_rot (
    .clk, .rst, .in_valid(start && !busy), .in_word, .tol(cfg.goal_tolerance),
    .o_valid(r_v), .o_drive(r_d), .o_status(r_s), .o_x(r_x), .o_y(r_y)
  );

  gtg_scale u_scl (
    .clk, .rst, .i_valid(r_v), .i_drive(r_d), .i_status(r_s), .i_x(r_x), .i_y(r_y),
    .lin_gain(cfg.linear_gain), .o_valid(l_v), .o_drive(l_d), .o_status(l_s),
    .o_lx(l_x), .o_ly(l_y)
  );

  gtg_atan u_atn (
    .clk, .rst, .i_valid(l_v), .i_drive(l_d), .i_status(l_s), .i_lx(l_x), .i_ly(l_y),
    .ang_gain(cfg.angular_gain), .o_valid(done), .o_word(out_word)
  );
endmodule
`default_nettype wire

// File: rtl/core/gtg_rotate.sv
`default_nettype none
// Front end: offset, reach test, pi fold and a pipelined rotation CORDIC.
module gtg_rotate (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire gtg_pkg::in_word_t     in_word,
  input  wire logic [14:0]           tol,
  output logic                       o_valid,
  output logic                       o_drive,
  output logic [1:0]                 o_status,
  output logic signed [gtg_pkg::RW-1:0] o_x,
  output logic signed [gtg_pkg::RW-1:0] o_y
);
  import gtg_pkg::*;

  // Stage 0: offsets, squares and the negated heading angle.
  logic              s0_v, s0_pv;
  logic signed [16:0] s0_dx, s0_dy;
  logic signed [ZW-1:0] s0_z;
  logic [33:0]       s0_dx2, s0_dy2;
  logic [29:0]       s0_tol2;

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else s0_v <= in_valid;
    s0_pv   <= in_word.pose_valid;
    s0_dx   <= 17'(in_word.goal_x) - 17'(in_word.pose_x);
    s0_dy   <= 17'(in_word.goal_y) - 17'(in_word.pose_y);
    s0_z    <= -(ZW'(in_word.pose_heading) <<< 15);
    s0_dx2  <= 34'($signed(17'(in_word.goal_x) - 17'(in_word.pose_x)) *
                   $signed(17'(in_word.goal_x) - 17'(in_word.pose_x)));
    s0_dy2  <= 34'($signed(17'(in_word.goal_y) - 17'(in_word.pose_y)) *
                   $signed(17'(in_word.goal_y) - 17'(in_word.pose_y)));
    s0_tol2 <= 30'(tol * tol);
  end

  // Stage 1: compare and fold.
  logic              c_v [NSTEPS+1];
  logic              c_d [NSTEPS+1];
  logic [1:0]        c_s [NSTEPS+1];
  logic signed [RW-1:0] c_x [NSTEPS+1];
  logic signed [RW-1:0] c_y [NSTEPS+1];
  logic signed [ZW-1:0] c_z [NSTEPS+1];

  logic signed [RW-1:0] gx, gy;
  logic reached;
  assign gx = RW'(s0_dx) <<< 8;
  assign gy = RW'(s0_dy) <<< 8;
  assign reached = ({1'b0, s0_dx2} + {1'b0, s0_dy2}) <= 35'(s0_tol2);

  always_ff @(posedge clk) begin
    if (rst) c_v[0] <= 1'b0;
    else c_v[0] <= s0_v;
    c_d[0] <= s0_pv && !reached;
    c_s[0] <= !s0_pv ? ST_NO_POSE : (reached ? ST_REACHED : ST_DRIVE);
    if (s0_z > HALF_PI_Q28) begin
      c_z[0] <= s0_z - PI_Q28; c_x[0] <= -gx; c_y[0] <= -gy;
    end else if (s0_z < -HALF_PI_Q28) begin
      c_z[0] <= s0_z + PI_Q28; c_x[0] <= -gx; c_y[0] <= -gy;
    end else begin
      c_z[0] <= s0_z; c_x[0] <= gx; c_y[0] <= gy;
    end
  end

  for (genvar i = 0; i < NSTEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) c_v[i+1] <= 1'b0;
      else c_v[i+1] <= c_v[i];
      c_d[i+1] <= c_d[i];
      c_s[i+1] <= c_s[i];
      if (c_z[i] >= 0) begin
        c_x[i+1] <= c_x[i] - (c_y[i] >>> i);
        c_y[i+1] <= c_y[i] + (c_x[i] >>> i);
        c_z[i+1] <= c_z[i] - atan_q28(i);
      end else begin
        c_x[i+1] <= c_x[i] + (c_y[i] >>> i);
        c_y[i+1] <= c_y[i] - (c_x[i] >>> i);
        c_z[i+1] <= c_z[i] + atan_q28(i);
      end
    end
  end

  assign o_valid  = c_v[NSTEPS];
  assign o_drive  = c_d[NSTEPS];
  assign o_status = c_s[NSTEPS];
  assign o_x      = c_x[NSTEPS];
  assign o_y      = c_y[NSTEPS];

  a_stat: assert property (@(posedge clk) disable iff (rst)
    c_v[0] |-> (c_d[0] == (c_s[0] == ST_DRIVE))) else $error("drive flag mismatch");
  a_nopose: assert property (@(posedge clk) disable iff (rst)
    (s0_v && !s0_pv) |=> (c_s[0] == ST_NO_POSE)) else $error("no-pose lost");
  a_vpipe: assert property (@(posedge clk) disable iff (rst)
    c_v[0] |=> ##(NSTEPS-1) c_v[NSTEPS]) else $error("valid dropped");
endmodule
`default_nettype wire

// File: rtl/core/gtg_scale.sv
`default_nettype none
// K scaling and linear gain, each in its own multiply stage, then a rounding stage.
module gtg_scale (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     i_valid,
  input  wire logic                     i_drive,
  input  wire logic [1:0]               i_status,
  input  wire logic signed [gtg_pkg::RW-1:0] i_x,
  input  wire logic signed [gtg_pkg::RW-1:0] i_y,
  input  wire logic [11:0]              lin_gain,
  output logic                          o_valid,
  output logic                          o_drive,
  output logic [1:0]                    o_status,
  output logic signed [47:0]            o_lx,
  output logic signed [47:0]            o_ly
);
  import gtg_pkg::*;

  logic v1, d1, v2, d2;
  logic [1:0] s1, s2;
  logic signed [52:0] px, py;
  logic signed [21:0] tx, ty;
  logic signed [34:0] qx, qy;

  assign tx = 22'((px + 53'sd2147483648) >>> 32);
  assign ty = 22'((py + 53'sd2147483648) >>> 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; o_valid <= 1'b0;
    end else begin
      v1 <= i_valid; v2 <= v1; o_valid <= v2;
    end
    d1 <= i_drive; s1 <= i_status;
    px <= 53'(i_x) * $signed({1'b0, GAIN_K_Q24});
    py <= 53'(i_y) * $signed({1'b0, GAIN_K_Q24});
    d2 <= d1; s2 <= s1;
    qx <= 35'(tx) * $signed({1'b0, lin_gain});
    qy <= 35'(ty) * $signed({1'b0, lin_gain});
    o_drive <= d2; o_status <= s2;
    o_lx <= 48'((qx + 35'sd128) >>> 8);
    o_ly <= 48'((qy + 35'sd128) >>> 8);
  end
endmodule
`default_nettype wire

// File: rtl/core/gtg_atan.sv
`default_nettype none
// Pipelined vectoring CORDIC for atan2 and the angular gain.
module gtg_atan (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                i_valid,
  input  wire logic                i_drive,
  input  wire logic [1:0]          i_status,
  input  wire logic signed [47:0]  i_lx,
  input  wire logic signed [47:0]  i_ly,
  input  wire logic [11:0]         ang_gain,
  output logic                     o_valid,
  output gtg_pkg::out_word_t       o_word
);
  import gtg_pkg::*;

  logic              a_v [NSTEPS+1];
  logic              a_d [NSTEPS+1];
  logic              a_k [NSTEPS+1];
  logic [1:0]        a_s [NSTEPS+1];
  logic signed [15:0] a_f [NSTEPS+1];
  logic signed [VW-1:0] a_x [NSTEPS+1];
  logic signed [VW-1:0] a_y [NSTEPS+1];
  logic signed [ZW-1:0] a_z [NSTEPS+1];

  // A zero y freezes the angle at its start value through all steps.
  always_ff @(posedge clk) begin
    if (rst) a_v[0] <= 1'b0;
    else a_v[0] <= i_valid;
    a_d[0] <= i_drive;
    a_s[0] <= i_status;
    a_f[0] <= sat16(i_lx);
    a_k[0] <= (i_ly == 0);
    if (i_ly == 0) begin
      a_z[0] <= (i_lx >= 0) ? '0 : PI_Q28;
      a_x[0] <= '0; a_y[0] <= '0;
    end else if (i_lx < 0) begin
      a_z[0] <= (i_ly > 0) ? PI_Q28 : -PI_Q28;
      a_x[0] <= -(VW'(i_lx) <<< 8);
      a_y[0] <= -(VW'(i_ly) <<< 8);
    end else begin
      a_z[0] <= '0;
      a_x[0] <= VW'(i_lx) <<< 8;
      a_y[0] <= VW'(i_ly) <<< 8;
    end
  end

  for (genvar i = 0; i < NSTEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) a_v[i+1] <= 1'b0;
      else a_v[i+1] <= a_v[i];
      a_d[i+1] <= a_d[i]; a_s[i+1] <= a_s[i];
      a_f[i+1] <= a_f[i]; a_k[i+1] <= a_k[i];
      if (a_k[i]) begin
        a_x[i+1] <= a_x[i]; a_y[i+1] <= a_y[i]; a_z[i+1] <= a_z[i];
      end else if (a_y[i] > 0) begin
        a_x[i+1] <= a_x[i] + (a_y[i] >>> i);
        a_y[i+1] <= a_y[i] - (a_x[i] >>> i);
        a_z[i+1] <= a_z[i] + atan_q28(i);
      end else begin
        a_x[i+1] <= a_x[i] - (a_y[i] >>> i);
        a_y[i+1] <= a_y[i] + (a_x[i] >>> i);
        a_z[i+1] <= a_z[i] - atan_q28(i);
      end
    end
  end

  logic              m_v, m_d;
  logic [1:0]        m_s;
  logic signed [15:0] m_f;
  logic signed [44:0] m_p;
  logic signed [47:0] rate;
  assign rate = 48'((m_p + 45'sd33554432) >>> 26);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0; o_valid <= 1'b0;
    end else begin
      m_v <= a_v[NSTEPS]; o_valid <= m_v;
    end
    m_d <= a_d[NSTEPS]; m_s <= a_s[NSTEPS]; m_f <= a_f[NSTEPS];
    m_p <= 45'(a_z[NSTEPS]) * $signed({1'b0, ang_gain});
    o_word.status        <= m_s;
    o_word.forward_speed <= m_d ? m_f : '0;
    o_word.turn_rate     <= m_d ? sat16(rate) : '0;
  end

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_word.status != ST_DRIVE) |->
      (o_word.forward_speed == 0 && o_word.turn_rate == 0)) else $error("nonzero idle drive");
  a_code: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_word.status != 2'd3)) else $error("bad status");
endmodule
`default_nettype wire
